FILE: rtl/slsc_pkg.sv
// Shared types, codes and fixed-point constants of the smoothed level state classifier.
// Used by every module of the block and by its checker; depends on nothing.
package slsc_pkg;

   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int CLASS_W               = 4;
   localparam int HEADING_W             = 3;
   localparam int CSR_INDEX_W           = 4;
   localparam int CSR_DATA_W            = 32;

   localparam logic [CLASS_W-1:0] CLASS_NEG   = 4'd0;
   localparam logic [CLASS_W-1:0] CLASS_ZERO  = 4'd1;
   localparam logic [CLASS_W-1:0] CLASS_POS   = 4'd2;
   localparam logic [CLASS_W-1:0] CLASS_MIX   = 4'd3;
   localparam logic [CLASS_W-1:0] CLASS_VOID  = 4'd4;
   localparam logic [CLASS_W-1:0] CLASS_EDGE  = 4'd5;
   localparam logic [CLASS_W-1:0] CLASS_FLOW  = 4'd6;
   localparam logic [CLASS_W-1:0] CLASS_LOCK  = 4'd7;
   localparam logic [CLASS_W-1:0] CLASS_NOISE = 4'd8;
   localparam logic [CLASS_W-1:0] CLASS_META  = 4'd9;

   localparam logic [HEADING_W-1:0] HEAD_NONE    = 3'd0;
   localparam logic [HEADING_W-1:0] HEAD_UP      = 3'd1;
   localparam logic [HEADING_W-1:0] HEAD_DOWN    = 3'd2;
   localparam logic [HEADING_W-1:0] HEAD_FORWARD = 3'd3;
   localparam logic [HEADING_W-1:0] HEAD_RECURSE = 3'd4;
   localparam logic [HEADING_W-1:0] HEAD_NULL    = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_CLASS     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HEADING   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COHERENCE = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ENTROPY   = 4'd3;

   // thresholds in Q16
   localparam logic [31:0] TQ_0199A = 32'h0000199A;
   localparam logic [31:0] TQ_03333 = 32'h00003333;
   localparam logic [31:0] TQ_04CCD = 32'h00004CCD;
   localparam logic [31:0] TQ_0599A = 32'h0000599A;
   localparam logic [31:0] TQ_06666 = 32'h00006666;
   localparam logic [31:0] TQ_08CCD = 32'h00008CCD;
   localparam logic [31:0] TQ_0999A = 32'h0000999A;
   localparam logic [31:0] TQ_0A666 = 32'h0000A666;
   localparam logic [31:0] TQ_0B333 = 32'h0000B333;
   localparam logic [31:0] TQ_0CCCD = 32'h0000CCCD;
   localparam logic [31:0] TQ_0D99A = 32'h0000D99A;
   localparam logic [31:0] TQ_0E666 = 32'h0000E666;

   typedef struct packed {
      logic [CLASS_W-1:0]   class_code;
      logic [HEADING_W-1:0] heading;
      logic                 repaired;
   } step_type;

   // rescale a Q16 threshold to the given number of fraction bits
   function automatic logic [63:0] th_scale(input logic [31:0] k, input int frac);
      th_scale = ({32'd0, k} << frac) >> 16;
   endfunction

endpackage

FILE: rtl/slsc_smooth.sv
// Saturating exponential average: floor(0.75*old) + floor(0.25*new), clamped to one.
// Depends on slsc_pkg for the default fraction width.
module slsc_smooth #(
   parameter int FRACTION_BITS = slsc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic [FRACTION_BITS:0] old_avg,
   input  logic [FRACTION_BITS:0] level,
   output logic [FRACTION_BITS:0] new_avg
);

   localparam int W = FRACTION_BITS + 1;
   localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;

   logic [W-1:0] old_sat;
   logic [W-1:0] lvl_sat;
   logic [W+1:0] triple;
   logic [W:0]   sum;

   always_comb begin
      old_sat = (old_avg > ONE) ? ONE : old_avg;
      lvl_sat = (level > ONE) ? ONE : level;
      triple  = {2'b00, old_sat} + {1'b0, old_sat, 1'b0};
      sum     = triple[W+1:2] + {3'b000, lvl_sat[W-1:2]};
      new_avg = (sum > {1'b0, ONE}) ? ONE : sum[W-1:0];
   end

endmodule

FILE: rtl/slsc_classify.sv
// Threshold transition table and invariant repair of the ten-state classifier.
// Depends on slsc_pkg for codes, thresholds and the step result struct.
module slsc_classify #(
   parameter int FRACTION_BITS = slsc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic [slsc_pkg::CLASS_W-1:0]   class_code,
   input  logic [slsc_pkg::HEADING_W-1:0] heading,
   input  logic [FRACTION_BITS:0]         coh,
   input  logic [FRACTION_BITS:0]         ent,
   input  logic [FRACTION_BITS:0]         noise_level,
   input  logic [FRACTION_BITS:0]         load_level,
   output slsc_pkg::step_type             step
);

   localparam int W = FRACTION_BITS + 1;
   localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;

   localparam logic [W-1:0] T_199A = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0199A, FRACTION_BITS));
   localparam logic [W-1:0] T_3333 = W'(slsc_pkg::th_scale(slsc_pkg::TQ_03333, FRACTION_BITS));
   localparam logic [W-1:0] T_4CCD = W'(slsc_pkg::th_scale(slsc_pkg::TQ_04CCD, FRACTION_BITS));
   localparam logic [W-1:0] T_599A = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0599A, FRACTION_BITS));
   localparam logic [W-1:0] T_6666 = W'(slsc_pkg::th_scale(slsc_pkg::TQ_06666, FRACTION_BITS));
   localparam logic [W-1:0] T_8CCD = W'(slsc_pkg::th_scale(slsc_pkg::TQ_08CCD, FRACTION_BITS));
   localparam logic [W-1:0] T_999A = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0999A, FRACTION_BITS));
   localparam logic [W-1:0] T_A666 = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0A666, FRACTION_BITS));
   localparam logic [W-1:0] T_B333 = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0B333, FRACTION_BITS));
   localparam logic [W-1:0] T_CCCD = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0CCCD, FRACTION_BITS));
   localparam logic [W-1:0] T_D99A = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0D99A, FRACTION_BITS));
   localparam logic [W-1:0] T_E666 = W'(slsc_pkg::th_scale(slsc_pkg::TQ_0E666, FRACTION_BITS));

   logic [W-1:0]                   noi;
   logic [W-1:0]                   ld;
   logic [W:0]                     ent_margin;
   logic [W:0]                     coh_margin;
   logic [slsc_pkg::CLASS_W-1:0]   next_class;
   logic [slsc_pkg::HEADING_W-1:0] next_heading;
   logic                           checked;
   logic                           bad;

   always_comb begin
      noi          = (noise_level > ONE) ? ONE : noise_level;
      ld           = (load_level > ONE) ? ONE : load_level;
      ent_margin   = {1'b0, ent} + {1'b0, T_199A};
      coh_margin   = {1'b0, coh} + {1'b0, T_199A};
      next_class   = class_code;
      next_heading = heading;
      checked      = 1'b1;
      case (class_code)
         slsc_pkg::CLASS_FLOW: begin
            if (coh > T_CCCD && noi < T_4CCD) begin
               next_class   = slsc_pkg::CLASS_LOCK;
               next_heading = slsc_pkg::HEAD_RECURSE;
            end else if (noi > T_B333 || ent > T_B333) begin
               next_class   = slsc_pkg::CLASS_NOISE;
               next_heading = slsc_pkg::HEAD_NONE;
            end
         end
         slsc_pkg::CLASS_LOCK: begin
            if (noi > T_8CCD || ent > T_A666) begin
               next_class   = slsc_pkg::CLASS_MIX;
               next_heading = slsc_pkg::HEAD_RECURSE;
            end else if (ld > T_D99A) begin
               next_class   = slsc_pkg::CLASS_EDGE;
               next_heading = slsc_pkg::HEAD_FORWARD;
            end
         end
         slsc_pkg::CLASS_MIX: begin
            if ({1'b0, coh} > ent_margin) begin
               next_class   = slsc_pkg::CLASS_POS;
               next_heading = slsc_pkg::HEAD_UP;
            end else if ({1'b0, ent} > coh_margin) begin
               next_class   = slsc_pkg::CLASS_NEG;
               next_heading = slsc_pkg::HEAD_DOWN;
            end else begin
               next_class   = slsc_pkg::CLASS_ZERO;
               next_heading = slsc_pkg::HEAD_NONE;
            end
         end
         slsc_pkg::CLASS_POS: begin
            if (ld > T_E666) begin
               next_class   = slsc_pkg::CLASS_EDGE;
               next_heading = slsc_pkg::HEAD_FORWARD;
            end else if (noi > T_999A) begin
               next_class   = slsc_pkg::CLASS_MIX;
               next_heading = slsc_pkg::HEAD_RECURSE;
            end
         end
         slsc_pkg::CLASS_NEG: begin
            if (noi < T_3333 && coh > T_999A) begin
               next_class   = slsc_pkg::CLASS_ZERO;
               next_heading = slsc_pkg::HEAD_NONE;
            end else if (ent > T_CCCD) begin
               next_class   = slsc_pkg::CLASS_VOID;
               next_heading = slsc_pkg::HEAD_NULL;
            end
         end
         slsc_pkg::CLASS_ZERO: begin
            if (coh > T_B333 && noi < T_6666) begin
               next_class   = slsc_pkg::CLASS_FLOW;
               next_heading = slsc_pkg::HEAD_FORWARD;
            end else if (noi > T_CCCD) begin
               next_class   = slsc_pkg::CLASS_NOISE;
               next_heading = slsc_pkg::HEAD_NONE;
            end
         end
         slsc_pkg::CLASS_EDGE: begin
            if (ld < T_999A && coh > T_999A) begin
               next_class   = slsc_pkg::CLASS_FLOW;
               next_heading = slsc_pkg::HEAD_FORWARD;
            end else if (noi > T_B333) begin
               next_class   = slsc_pkg::CLASS_MIX;
               next_heading = slsc_pkg::HEAD_RECURSE;
            end
         end
         slsc_pkg::CLASS_NOISE: begin
            if (noi < T_599A && coh > T_8CCD) begin
               next_class   = slsc_pkg::CLASS_ZERO;
               next_heading = slsc_pkg::HEAD_NONE;
            end else if (ent > T_E666) begin
               next_class   = slsc_pkg::CLASS_VOID;
               next_heading = slsc_pkg::HEAD_NULL;
            end
         end
         slsc_pkg::CLASS_VOID: begin
            if (coh > T_CCCD && noi < T_3333) begin
               next_class   = slsc_pkg::CLASS_ZERO;
               next_heading = slsc_pkg::HEAD_NONE;
            end
         end
         slsc_pkg::CLASS_META: begin
            if (ent > coh) begin
               next_class   = slsc_pkg::CLASS_MIX;
               next_heading = slsc_pkg::HEAD_RECURSE;
            end else if (coh > T_D99A) begin
               next_class   = slsc_pkg::CLASS_LOCK;
               next_heading = slsc_pkg::HEAD_RECURSE;
            end
         end
         default: begin
            checked = 1'b0;
         end
      endcase

      bad = 1'b0;
      if (next_class == slsc_pkg::CLASS_VOID && next_heading != slsc_pkg::HEAD_NONE
          && next_heading != slsc_pkg::HEAD_NULL) begin
         bad = 1'b1;
      end
      if (next_class == slsc_pkg::CLASS_META && coh < ent) begin
         bad = 1'b1;
      end

      if (checked && bad) begin
         step.class_code = slsc_pkg::CLASS_ZERO;
         step.heading    = slsc_pkg::HEAD_NONE;
         step.repaired   = 1'b1;
      end else begin
         step.class_code = next_class;
         step.heading    = next_heading;
         step.repaired   = 1'b0;
      end
   end

endmodule

FILE: rtl/smoothed_level_state_classifier.sv
// Top level of the smoothed level state classifier: request register, node state,
// start registers and response register. Depends on slsc_pkg, slsc_smooth, slsc_classify.
//
// Usage:
//   Request channel (req_valid/req_ready) carries a restart bit and four Q16 levels.
//   Response channel (rsp_valid/rsp_ready) returns the new class, heading, both
//   smoothed averages and the repaired flag, one response per request, in order.
//   Configuration channel (csr_valid/csr_ready, csr_index, csr_wdata) writes the
//   four start registers; it is always ready and unknown indexes are dropped.
//   Write it only while no request is in flight.
// Path: an accepted request goes into the request register, then through the averaging
//   and classification logic into the response register, which drives the response.
// Throughput: one request per cycle while the response channel is not stalled; the node
//   state that the next request reads is updated as each request advances.
// Reset: synchronous, active high; empties both registers, loads ZERO/NONE with
//   zero averages and restores the start registers to their reset values.
// Stall: a pending response holds while rsp_ready is low; one further request is
//   held in the request register, after which req_ready drops.
module smoothed_level_state_classifier #(
   parameter int FRACTION_BITS = slsc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_restart,
   input  logic [FRACTION_BITS:0]             req_coherence_level,
   input  logic [FRACTION_BITS:0]             req_entropy_level,
   input  logic [FRACTION_BITS:0]             req_noise_level,
   input  logic [FRACTION_BITS:0]             req_load_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [slsc_pkg::CLASS_W-1:0]       rsp_class_code,
   output logic [slsc_pkg::HEADING_W-1:0]     rsp_heading,
   output logic [FRACTION_BITS:0]             rsp_smoothed_coherence,
   output logic [FRACTION_BITS:0]             rsp_smoothed_entropy,
   output logic                               rsp_repaired,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [slsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [slsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int W = FRACTION_BITS + 1;

   logic                           in_valid_ff;
   logic                           restart_ff;
   logic [W-1:0]                   coh_lvl_ff;
   logic [W-1:0]                   ent_lvl_ff;
   logic [W-1:0]                   noi_lvl_ff;
   logic [W-1:0]                   ld_lvl_ff;

   logic [slsc_pkg::CLASS_W-1:0]   class_ff;
   logic [slsc_pkg::HEADING_W-1:0] heading_ff;
   logic [W-1:0]                   coh_avg_ff;
   logic [W-1:0]                   ent_avg_ff;

   logic [slsc_pkg::CLASS_W-1:0]   start_class_ff;
   logic [slsc_pkg::HEADING_W-1:0] start_heading_ff;
   logic [W-1:0]                   start_coh_ff;
   logic [W-1:0]                   start_ent_ff;

   logic                           out_valid_ff;
   slsc_pkg::step_type             out_step_ff;
   logic [W-1:0]                   out_coh_ff;
   logic [W-1:0]                   out_ent_ff;

   logic                           out_free;
   logic                           advance;
   logic                           accept;
   logic [slsc_pkg::CLASS_W-1:0]   class_src;
   logic [slsc_pkg::HEADING_W-1:0] heading_src;
   logic [W-1:0]                   coh_src;
   logic [W-1:0]                   ent_src;
   logic [W-1:0]                   coh_avg_in;
   logic [W-1:0]                   ent_avg_in;
   slsc_pkg::step_type             step_in;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (restart_ff) begin
         class_src   = start_class_ff;
         heading_src = start_heading_ff;
         coh_src     = start_coh_ff;
         ent_src     = start_ent_ff;
      end else begin
         class_src   = class_ff;
         heading_src = heading_ff;
         coh_src     = coh_avg_ff;
         ent_src     = ent_avg_ff;
      end
   end

   slsc_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_smooth_coh (
      .old_avg (coh_src),
      .level   (coh_lvl_ff),
      .new_avg (coh_avg_in)
   );

   slsc_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_smooth_ent (
      .old_avg (ent_src),
      .level   (ent_lvl_ff),
      .new_avg (ent_avg_in)
   );

   slsc_classify #(.FRACTION_BITS(FRACTION_BITS)) u_classify (
      .class_code  (class_src),
      .heading     (heading_src),
      .coh         (coh_avg_in),
      .ent         (ent_avg_in),
      .noise_level (noi_lvl_ff),
      .load_level  (ld_lvl_ff),
      .step        (step_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         restart_ff <= req_restart;
         coh_lvl_ff <= req_coherence_level;
         ent_lvl_ff <= req_entropy_level;
         noi_lvl_ff <= req_noise_level;
         ld_lvl_ff  <= req_load_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff   <= slsc_pkg::CLASS_ZERO;
         heading_ff <= slsc_pkg::HEAD_NONE;
         coh_avg_ff <= '0;
         ent_avg_ff <= '0;
      end else if (advance) begin
         class_ff   <= step_in.class_code;
         heading_ff <= step_in.heading;
         coh_avg_ff <= coh_avg_in;
         ent_avg_ff <= ent_avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_class_ff   <= slsc_pkg::CLASS_ZERO;
         start_heading_ff <= slsc_pkg::HEAD_NONE;
         start_coh_ff     <= '0;
         start_ent_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            slsc_pkg::CSR_START_CLASS:     start_class_ff   <= csr_wdata[slsc_pkg::CLASS_W-1:0];
            slsc_pkg::CSR_START_HEADING:   start_heading_ff <= csr_wdata[slsc_pkg::HEADING_W-1:0];
            slsc_pkg::CSR_START_COHERENCE: start_coh_ff     <= csr_wdata[W-1:0];
            slsc_pkg::CSR_START_ENTROPY:   start_ent_ff     <= csr_wdata[W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_step_ff <= step_in;
         out_coh_ff  <= coh_avg_in;
         out_ent_ff  <= ent_avg_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_class_code         = out_step_ff.class_code;
   assign rsp_heading            = out_step_ff.heading;
   assign rsp_repaired           = out_step_ff.repaired;
   assign rsp_smoothed_coherence = out_coh_ff;
   assign rsp_smoothed_entropy   = out_ent_ff;

endmodule

FILE: rtl/slsc_checker.sv
// Port-level checker for the smoothed level state classifier, bound to the top level.
// Depends on slsc_pkg for class and heading codes.
module slsc_checker #(
   parameter int FRACTION_BITS = slsc_pkg::FRACTION_BITS_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [slsc_pkg::CLASS_W-1:0]   rsp_class_code,
   input logic [slsc_pkg::HEADING_W-1:0] rsp_heading,
   input logic [FRACTION_BITS:0]         rsp_smoothed_coherence,
   input logic [FRACTION_BITS:0]         rsp_smoothed_entropy,
   input logic                           rsp_repaired
);

   localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_class_code)
         && $stable(rsp_heading) && $stable(rsp_smoothed_coherence)
         && $stable(rsp_smoothed_entropy) && $stable(rsp_repaired))
      else $error("stalled response changed");

   a_repair_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repaired |-> rsp_class_code == slsc_pkg::CLASS_ZERO
         && rsp_heading == slsc_pkg::HEAD_NONE)
      else $error("repaired response not ZERO/NONE");

   a_void_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class_code == slsc_pkg::CLASS_VOID |->
         rsp_heading == slsc_pkg::HEAD_NONE || rsp_heading == slsc_pkg::HEAD_NULL)
      else $error("VOID response with bad heading");

   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_smoothed_coherence <= ONE && rsp_smoothed_entropy <= ONE)
      else $error("smoothed average above one");

endmodule

bind smoothed_level_state_classifier slsc_checker #(.FRACTION_BITS(FRACTION_BITS)) u_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_class_code         (rsp_class_code),
   .rsp_heading            (rsp_heading),
   .rsp_smoothed_coherence (rsp_smoothed_coherence),
   .rsp_smoothed_entropy   (rsp_smoothed_entropy),
   .rsp_repaired           (rsp_repaired)
);

FILE: verif/slsc_checker.sv
// Response checker for the smoothed level state classifier: watches the start-register,
// request and response channels, predicts each response and compares it field by field.
// Depends on slsc_pkg for the class, heading and register index codes.
module slsc_resp_checker
   import slsc_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_restart,
   input  logic [FRACTION_BITS_DEFAULT:0]  req_coherence_level,
   input  logic [FRACTION_BITS_DEFAULT:0]  req_entropy_level,
   input  logic [FRACTION_BITS_DEFAULT:0]  req_noise_level,
   input  logic [FRACTION_BITS_DEFAULT:0]  req_load_level,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [CLASS_W-1:0]              rsp_class_code,
   input  logic [HEADING_W-1:0]            rsp_heading,
   input  logic [FRACTION_BITS_DEFAULT:0]  rsp_smoothed_coherence,
   input  logic [FRACTION_BITS_DEFAULT:0]  rsp_smoothed_entropy,
   input  logic                            rsp_repaired,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [CSR_INDEX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int LW = FRACTION_BITS_DEFAULT + 1;
   localparam int WW = LW + 3;
   localparam logic [WW-1:0] LEVEL_ONE = WW'(1) << FRACTION_BITS_DEFAULT;

   typedef struct packed {
      logic [CLASS_W-1:0]   class_code;
      logic [HEADING_W-1:0] heading;
      logic [LW-1:0]        smoothed_coherence;
      logic [LW-1:0]        smoothed_entropy;
      logic                 repaired;
   } node_outcome_t;

   node_outcome_t          expected_outcomes[$];
   node_outcome_t          got_outcome;
   node_outcome_t          want_outcome;
   logic [CLASS_W-1:0]     node_class;
   logic [HEADING_W-1:0]   node_heading;
   logic [LW-1:0]          node_coh;
   logic [LW-1:0]          node_ent;
   logic [CLASS_W-1:0]     start_class;
   logic [HEADING_W-1:0]   start_heading;
   logic [LW-1:0]          start_coh;
   logic [LW-1:0]          start_ent;

   function automatic logic [LW-1:0] clip(input logic [WW-1:0] v);
      clip = (v > LEVEL_ONE) ? LEVEL_ONE[LW-1:0] : v[LW-1:0];
   endfunction

   function automatic logic [LW-1:0] blend(input logic [LW-1:0] old_avg,
                                           input logic [LW-1:0] level);
      logic [WW-1:0] old_sat;
      logic [WW-1:0] three_quarters;
      logic [WW-1:0] quarter;
      old_sat        = {3'b000, clip({3'b000, old_avg})};
      three_quarters = (old_sat + (old_sat << 1)) >> 2;
      quarter        = {3'b000, clip({3'b000, level})} >> 2;
      blend          = clip(three_quarters + quarter);
   endfunction

   function automatic logic [WW-1:0] lim(input logic [31:0] k);
      logic [63:0] scaled;
      scaled = ({32'd0, k} << FRACTION_BITS_DEFAULT) >> 16;
      lim    = scaled[WW-1:0];
   endfunction

   task automatic move(input logic [CLASS_W-1:0] cls, input logic [HEADING_W-1:0] hd);
      node_class   = cls;
      node_heading = hd;
   endtask

   task automatic predict_step(input  logic          restart,
                               input  logic [LW-1:0] coh_in,
                               input  logic [LW-1:0] ent_in,
                               input  logic [LW-1:0] noi_in,
                               input  logic [LW-1:0] ld_in,
                               output node_outcome_t res);
      logic [WW-1:0] coh;
      logic [WW-1:0] ent;
      logic [WW-1:0] noi;
      logic [WW-1:0] ld;
      logic          known;
      logic          bad;
      if (restart) begin
         node_class   = start_class;
         node_heading = start_heading;
         node_coh     = start_coh;
         node_ent     = start_ent;
      end
      node_coh = blend(node_coh, coh_in);
      node_ent = blend(node_ent, ent_in);
      coh      = {3'b000, node_coh};
      ent      = {3'b000, node_ent};
      noi      = {3'b000, clip({3'b000, noi_in})};
      ld       = {3'b000, clip({3'b000, ld_in})};
      known    = 1'b1;
      bad      = 1'b0;
      case (node_class)
         CLASS_FLOW: begin
            if (coh > lim(TQ_0CCCD) && noi < lim(TQ_04CCD)) move(CLASS_LOCK, HEAD_RECURSE);
            else if (noi > lim(TQ_0B333) || ent > lim(TQ_0B333)) move(CLASS_NOISE, HEAD_NONE);
         end
         CLASS_LOCK: begin
            if (noi > lim(TQ_08CCD) || ent > lim(TQ_0A666)) move(CLASS_MIX, HEAD_RECURSE);
            else if (ld > lim(TQ_0D99A)) move(CLASS_EDGE, HEAD_FORWARD);
         end
         CLASS_MIX: begin
            if (coh > ent + lim(TQ_0199A)) move(CLASS_POS, HEAD_UP);
            else if (ent > coh + lim(TQ_0199A)) move(CLASS_NEG, HEAD_DOWN);
            else move(CLASS_ZERO, HEAD_NONE);
         end
         CLASS_POS: begin
            if (ld > lim(TQ_0E666)) move(CLASS_EDGE, HEAD_FORWARD);
            else if (noi > lim(TQ_0999A)) move(CLASS_MIX, HEAD_RECURSE);
         end
         CLASS_NEG: begin
            if (noi < lim(TQ_03333) && coh > lim(TQ_0999A)) move(CLASS_ZERO, HEAD_NONE);
            else if (ent > lim(TQ_0CCCD)) move(CLASS_VOID, HEAD_NULL);
         end
         CLASS_ZERO: begin
            if (coh > lim(TQ_0B333) && noi < lim(TQ_06666)) move(CLASS_FLOW, HEAD_FORWARD);
            else if (noi > lim(TQ_0CCCD)) move(CLASS_NOISE, HEAD_NONE);
         end
         CLASS_EDGE: begin
            if (ld < lim(TQ_0999A) && coh > lim(TQ_0999A)) move(CLASS_FLOW, HEAD_FORWARD);
            else if (noi > lim(TQ_0B333)) move(CLASS_MIX, HEAD_RECURSE);
         end
         CLASS_NOISE: begin
            if (noi < lim(TQ_0599A) && coh > lim(TQ_08CCD)) move(CLASS_ZERO, HEAD_NONE);
            else if (ent > lim(TQ_0E666)) move(CLASS_VOID, HEAD_NULL);
         end
         CLASS_VOID: begin
            if (coh > lim(TQ_0CCCD) && noi < lim(TQ_03333)) move(CLASS_ZERO, HEAD_NONE);
         end
         CLASS_META: begin
            if (ent > coh) move(CLASS_MIX, HEAD_RECURSE);
            else if (coh > lim(TQ_0D99A)) move(CLASS_LOCK, HEAD_RECURSE);
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (known) begin
         if (node_class == CLASS_VOID && node_heading != HEAD_NONE && node_heading != HEAD_NULL)
            bad = 1'b1;
         if (node_class == CLASS_META && coh < ent)
            bad = 1'b1;
         if (bad) move(CLASS_ZERO, HEAD_NONE);
      end
      res = {node_class, node_heading, node_coh, node_ent, bad};
   endtask

   task automatic report_mismatch(input string what);
      $display("slsc_checker: %0t: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         node_class    = CLASS_ZERO;
         node_heading  = HEAD_NONE;
         node_coh      = '0;
         node_ent      = '0;
         start_class   = CLASS_ZERO;
         start_heading = HEAD_NONE;
         start_coh     = '0;
         start_ent     = '0;
         expected_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_CLASS:     start_class   = csr_wdata[CLASS_W-1:0];
               CSR_START_HEADING:   start_heading = csr_wdata[HEADING_W-1:0];
               CSR_START_COHERENCE: start_coh     = csr_wdata[LW-1:0];
               CSR_START_ENTROPY:   start_ent     = csr_wdata[LW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got_outcome = {rsp_class_code, rsp_heading, rsp_smoothed_coherence,
                           rsp_smoothed_entropy, rsp_repaired};
            if (expected_outcomes.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want_outcome = expected_outcomes.pop_front();
               if (got_outcome != want_outcome)
                  report_mismatch($sformatf(
                     "got/exp class %0d/%0d heading %0d/%0d coh %0d/%0d ent %0d/%0d rep %0d/%0d",
                     got_outcome.class_code, want_outcome.class_code,
                     got_outcome.heading, want_outcome.heading,
                     got_outcome.smoothed_coherence, want_outcome.smoothed_coherence,
                     got_outcome.smoothed_entropy, want_outcome.smoothed_entropy,
                     got_outcome.repaired, want_outcome.repaired));
            end
         end
         if (req_valid && req_ready) begin
            predict_step(req_restart, req_coherence_level, req_entropy_level,
                         req_noise_level, req_load_level, want_outcome);
            expected_outcomes.push_back(want_outcome);
         end
      end
      pending_count <= expected_outcomes.size();
   end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the smoothed level state classifier: clock, reset, request and
// start-register stimulus, response back-pressure and the verdict.
// Depends on slsc_pkg, smoothed_level_state_classifier and slsc_resp_checker.
module tb_top;
   import slsc_pkg::*;

   localparam int LW          = FRACTION_BITS_DEFAULT + 1;
   localparam int HOLD_CYCLES = 60;
   localparam int RUN_LENGTH  = 8;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 58;

   localparam logic [LW-1:0]        LEVEL_ONE  = LW'(1) << FRACTION_BITS_DEFAULT;
   localparam logic [LW-1:0]        LEVEL_HALF = LEVEL_ONE >> 1;
   localparam logic [LW-1:0]        LEVEL_MAX  = '1;
   localparam logic [LW-1:0]        LEVEL_NIL  = '0;
   localparam logic [CLASS_W-1:0]   CLASS_OUT  = CLASS_META + CLASS_W'(3);
   localparam logic [CLASS_W-1:0]   CLASS_TOP  = '1;
   localparam logic [HEADING_W-1:0] HEAD_OUT   = HEAD_NULL + HEADING_W'(1);
   localparam logic [HEADING_W-1:0] HEAD_TOP   = '1;

   typedef enum int {BAND_LOW, BAND_MID, BAND_HIGH, BAND_OVER, BAND_ANY, BAND_EXTREME}
      level_band_e;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_restart = 1'b0;
   logic [LW-1:0]          req_coherence_level = '0;
   logic [LW-1:0]          req_entropy_level = '0;
   logic [LW-1:0]          req_noise_level = '0;
   logic [LW-1:0]          req_load_level = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CLASS_W-1:0]     rsp_class_code;
   logic [HEADING_W-1:0]   rsp_heading;
   logic [LW-1:0]          rsp_smoothed_coherence;
   logic [LW-1:0]          rsp_smoothed_entropy;
   logic                   rsp_repaired;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int req_idle_pct = 31;
   int rsp_idle_pct = 80;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int fail_count;
   int pending_count;

   smoothed_level_state_classifier u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_restart            (req_restart),
      .req_coherence_level    (req_coherence_level),
      .req_entropy_level      (req_entropy_level),
      .req_noise_level        (req_noise_level),
      .req_load_level         (req_load_level),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_class_code         (rsp_class_code),
      .rsp_heading            (rsp_heading),
      .rsp_smoothed_coherence (rsp_smoothed_coherence),
      .rsp_smoothed_entropy   (rsp_smoothed_entropy),
      .rsp_repaired           (rsp_repaired),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   slsc_resp_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_restart            (req_restart),
      .req_coherence_level    (req_coherence_level),
      .req_entropy_level      (req_entropy_level),
      .req_noise_level        (req_noise_level),
      .req_load_level         (req_load_level),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_class_code         (rsp_class_code),
      .rsp_heading            (rsp_heading),
      .rsp_smoothed_coherence (rsp_smoothed_coherence),
      .rsp_smoothed_entropy   (rsp_smoothed_entropy),
      .rsp_repaired           (rsp_repaired),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .fail_count             (fail_count),
      .pending_count          (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hold off for a long stretch on request, otherwise stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_ask) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic logic [LW-1:0] pick_level(input level_band_e band);
      case (band)
         BAND_LOW:  pick_level = LW'($urandom_range(32'h3000));
         BAND_MID:  pick_level = LW'($urandom_range(32'hD000, 32'h3000));
         BAND_HIGH: pick_level = LW'($urandom_range(LEVEL_ONE, 32'hC000));
         BAND_OVER: pick_level = LW'($urandom_range(LEVEL_MAX, LEVEL_ONE));
         BAND_ANY:  pick_level = LW'($urandom_range(LEVEL_MAX));
         default:   pick_level = $urandom_range(1) ? LEVEL_ONE :
                                 ($urandom_range(1) ? LEVEL_MAX : LEVEL_NIL);
      endcase
   endfunction

   task automatic wait_drained;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic idle_gap;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_req(input logic          restart,
                           input logic [LW-1:0] coh,
                           input logic [LW-1:0] ent,
                           input logic [LW-1:0] noi,
                           input logic [LW-1:0] ld);
      req_valid           <= 1'b1;
      req_restart         <= restart;
      req_coherence_level <= coh;
      req_entropy_level   <= ent;
      req_noise_level     <= noi;
      req_load_level      <= ld;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drain, then load all start registers plus one unmapped index; unused bits are noise
   task automatic load_start(input logic [CLASS_W-1:0]   cls,
                             input logic [HEADING_W-1:0] hd,
                             input logic [LW-1:0]        coh,
                             input logic [LW-1:0]        ent);
      logic [CSR_INDEX_W-1:0] stray;
      stray = CSR_INDEX_W'($urandom_range(15, CSR_START_ENTROPY + 1));
      req_valid <= 1'b0;
      wait_drained();
      write_csr(CSR_START_CLASS,     ($urandom() & ~32'hF) | CSR_DATA_W'(cls));
      write_csr(CSR_START_HEADING,   ($urandom() & ~32'h7) | CSR_DATA_W'(hd));
      write_csr(CSR_START_COHERENCE, ($urandom() & ~32'h1FFFF) | CSR_DATA_W'(coh));
      write_csr(CSR_START_ENTROPY,   ($urandom() & ~32'h1FFFF) | CSR_DATA_W'(ent));
      write_csr(stray, $urandom());
      csr_valid <= 1'b0;
   endtask

   task automatic directed_case(input logic [CLASS_W-1:0]   cls,
                                input logic [HEADING_W-1:0] hd,
                                input logic [LW-1:0]        coh0,
                                input logic [LW-1:0]        ent0,
                                input int                   count,
                                input logic [LW-1:0]        coh,
                                input logic [LW-1:0]        ent,
                                input logic [LW-1:0]        noi,
                                input logic [LW-1:0]        ld);
      load_start(cls, hd, coh0, ent0);
      for (int i = 0; i < count; i++) begin
         idle_gap();
         send_req(i == 0, coh, ent, noi, ld);
      end
   endtask

   initial begin
      level_band_e          bands [4];
      logic [CLASS_W-1:0]   cls;
      logic [HEADING_W-1:0] hd;
      logic [LW-1:0]        coh0;
      logic [LW-1:0]        ent0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_case(CLASS_ZERO, HEAD_NONE, LEVEL_NIL, LEVEL_NIL, 2,
                    LEVEL_NIL, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_ZERO, HEAD_NONE, LEVEL_NIL, LEVEL_NIL, 2,
                    LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      directed_case(CLASS_ZERO, HEAD_NONE, LEVEL_ONE, LEVEL_NIL, 1,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_FLOW, HEAD_FORWARD, LEVEL_ONE, LEVEL_NIL, 3,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_ONE);
      directed_case(CLASS_FLOW, HEAD_FORWARD, LEVEL_NIL, LEVEL_ONE, 1,
                    LEVEL_NIL, LEVEL_ONE, LEVEL_ONE, LEVEL_NIL);
      directed_case(CLASS_LOCK, HEAD_RECURSE, LEVEL_NIL, LEVEL_ONE, 1,
                    LEVEL_NIL, LEVEL_ONE, LEVEL_ONE, LEVEL_NIL);
      directed_case(CLASS_MIX, HEAD_RECURSE, LEVEL_ONE, LEVEL_NIL, 2,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_ONE);
      directed_case(CLASS_MIX, HEAD_RECURSE, LEVEL_NIL, LEVEL_ONE, 3,
                    LEVEL_NIL, LEVEL_ONE, LEVEL_ONE, LEVEL_NIL);
      directed_case(CLASS_MIX, HEAD_RECURSE, LEVEL_HALF, LEVEL_HALF, 1,
                    LEVEL_HALF, LEVEL_HALF, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_VOID, HEAD_UP, LEVEL_NIL, LEVEL_NIL, 1,
                    LEVEL_NIL, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_VOID, HEAD_TOP, LEVEL_NIL, LEVEL_NIL, 1,
                    LEVEL_NIL, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_META, HEAD_NONE, LEVEL_ONE, LEVEL_NIL, 1,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_META, HEAD_NONE, LEVEL_NIL, LEVEL_ONE, 1,
                    LEVEL_NIL, LEVEL_ONE, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_OUT, HEAD_OUT, LEVEL_MAX, LEVEL_MAX, 2,
                    LEVEL_MAX, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_NOISE, HEAD_NONE, LEVEL_ONE, LEVEL_NIL, 1,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_NOISE, HEAD_NONE, LEVEL_NIL, LEVEL_ONE, 1,
                    LEVEL_NIL, LEVEL_ONE, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_POS, HEAD_UP, LEVEL_HALF, LEVEL_HALF, 1,
                    LEVEL_HALF, LEVEL_HALF, LEVEL_ONE, LEVEL_NIL);
      directed_case(CLASS_EDGE, HEAD_FORWARD, LEVEL_NIL, LEVEL_NIL, 1,
                    LEVEL_NIL, LEVEL_NIL, LEVEL_ONE, LEVEL_ONE);
      directed_case(CLASS_EDGE, HEAD_FORWARD, LEVEL_ONE, LEVEL_NIL, 1,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);
      directed_case(CLASS_NEG, HEAD_DOWN, LEVEL_ONE, LEVEL_NIL, 1,
                    LEVEL_ONE, LEVEL_NIL, LEVEL_NIL, LEVEL_NIL);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            cls = CLASS_NEG;  hd = HEAD_NONE; coh0 = LEVEL_NIL; ent0 = LEVEL_NIL;
         end else if (p == 1) begin
            cls = CLASS_TOP;  hd = HEAD_TOP;  coh0 = LEVEL_MAX; ent0 = LEVEL_MAX;
         end else if (p == 4) begin
            cls = CLASS_META; hd = HEAD_NULL; coh0 = LEVEL_ONE; ent0 = LEVEL_ONE;
         end else begin
            cls  = ($urandom_range(3) == 0)
                      ? CLASS_W'($urandom_range(CLASS_TOP, CLASS_META + 1))
                      : CLASS_W'($urandom_range(CLASS_META));
            hd   = HEADING_W'($urandom_range(HEAD_TOP));
            coh0 = pick_level(level_band_e'($urandom_range(BAND_EXTREME)));
            ent0 = pick_level(level_band_e'($urandom_range(BAND_EXTREME)));
         end
         load_start(cls, hd, coh0, ent0);
         req_idle_pct  = (p < 3) ? 31 : (p < 6) ? 80 : 0;
         rsp_idle_pct <= (p < 3) ? 80 : (p < 6) ? 31 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % RUN_LENGTH == 0) begin
               for (int k = 0; k < 4; k++)
                  bands[k] = level_band_e'($urandom_range(BAND_EXTREME));
            end
            if (i == 5 && (p == 2 || p == 6))
               hold_ask <= hold_ask + 1;
            if (i == 30 && p == 4) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            idle_gap();
            send_req($urandom_range(19) == 0, pick_level(bands[0]), pick_level(bands[1]),
                     pick_level(bands[2]), pick_level(bands[3]));
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[smoothed_level_state_classifier] OK");
      end else begin
         $display("[smoothed_level_state_classifier] ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("[smoothed_level_state_classifier] ERROR");
      $finish;
   end

endmodule

FILE: smoothed_level_state_classifier.f
rtl/slsc_pkg.sv
rtl/slsc_smooth.sv
rtl/slsc_classify.sv
rtl/smoothed_level_state_classifier.sv
rtl/slsc_checker.sv
verif/slsc_checker.sv
verif/tb_top.sv
